// File: hdl/grid_astar_path_search_unit_defines.svh
// ----------------------------------------------------------------------------
// Grid A* path search unit: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define GASP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define GASP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/gasp_pkg.sv
// ----------------------------------------------------------------------------
// Grid A* path search package
// Widths, codes, node record type and step tables shared by the design.
// ----------------------------------------------------------------------------
package gasp_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_W     = 10;
    localparam int LEN_W      = 11;
    localparam int DIM_W      = 6;
    localparam int G_W        = 11;
    localparam int H_W        = 6;
    localparam int ORDER_W    = 16;
    localparam int F_W        = G_W + 1;

    localparam logic [LEN_W-1:0] NO_PARENT = LEN_W'(CELLS);

    // Operation codes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PATH = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Per-node tags.
    localparam logic [1:0] TAG_NONE   = 2'd0;
    localparam logic [1:0] TAG_OPEN   = 2'd1;
    localparam logic [1:0] TAG_CLOSED = 2'd2;
    localparam logic [1:0] TAG_DEAD   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam int PADDR_W = 4;

    // Neighbour steps: the first four are the orthogonal ones.
    localparam logic signed [1:0] STEP_DX [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                                  -2'sd1, -2'sd1, 2'sd1, 2'sd1};
    localparam logic signed [1:0] STEP_DY [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                                  2'sd1, -2'sd1, 2'sd1, -2'sd1};

    typedef struct packed {
        logic [1:0]         tag;
        logic [G_W-1:0]     g;
        logic [H_W-1:0]     h;
        logic [LEN_W-1:0]   parent;
        logic [ORDER_W-1:0] order;
    } node_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             diag;
        logic [LEN_W-1:0] cells;
    } grid_cfg_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [LEN_W-1:0]  path_length;
        logic [CELL_W-1:0] path_cell;
    } result_t;

endpackage

// File: hdl/gasp_in_if.sv
// ----------------------------------------------------------------------------
// Grid A* path search channel interfaces
// Input item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gasp_in_if
    import gasp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [CELL_W-1:0] cell_index;
    logic              cell_passable;
    logic [CELL_W-1:0] start_cell;
    logic [CELL_W-1:0] end_cell;
    logic [CELL_W-1:0] path_step;

    modport source (output valid, operation, cell_index, cell_passable, start_cell,
                    end_cell, path_step, input ready);
    modport sink (input valid, operation, cell_index, cell_passable, start_cell,
                  end_cell, path_step, output ready);
endinterface

interface gasp_out_if
    import gasp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [LEN_W-1:0]  path_length;
    logic [CELL_W-1:0] path_cell;

    modport source (output valid, status, path_length, path_cell, input ready);
    modport sink (input valid, status, path_length, path_cell, output ready);
endinterface

// File: hdl/gasp_cfg.sv
// ----------------------------------------------------------------------------
// Grid A* path search configuration registers
// APB-style register file; presents the clamped grid size and cell count.
// ----------------------------------------------------------------------------
module gasp_cfg
    import gasp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output grid_cfg_t          cfg
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             mode_reg;
    logic             wr_en;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            mode_reg   <= 1'b0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_MODE:   mode_reg   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_reg};
            REG_MODE:   prdata = {31'd0, mode_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // A size of zero counts as one; anything above the maximum counts as it.
    always_comb begin
        if (width_reg == '0)
            cfg.width = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            cfg.width = DIM_W'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg == '0)
            cfg.height = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            cfg.height = DIM_W'(MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.diag  = mode_reg;
        cfg.cells = LEN_W'(cfg.width * cfg.height);
    end

endmodule

// File: hdl/gasp_core.sv
// ----------------------------------------------------------------------------
// Grid A* path search engine
// Map, node and path memories with the sequencer that runs one item at a time.
// ----------------------------------------------------------------------------
module gasp_core
    import gasp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  grid_cfg_t         cfg,
    input  logic              go,
    input  logic [1:0]        operation,
    input  logic [CELL_W-1:0] cell_index,
    input  logic              cell_passable,
    input  logic [CELL_W-1:0] start_cell,
    input  logic [CELL_W-1:0] end_cell,
    input  logic [CELL_W-1:0] path_step,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    typedef enum logic [11:0] {
        S_INIT   = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_CLEAR  = 12'b0000_0000_0100,
        S_SEED   = 12'b0000_0000_1000,
        S_SCAN   = 12'b0000_0001_0000,
        S_CLOSE  = 12'b0000_0010_0000,
        S_NB_RD  = 12'b0000_0100_0000,
        S_NB_WR  = 12'b0000_1000_0000,
        S_WALK   = 12'b0001_0000_0000,
        S_WCHK   = 12'b0010_0000_0000,
        S_PREAD  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Memories.
    logic  blocked_mem [CELLS];
    node_t node_mem [CELLS];
    logic [CELL_W-1:0] path_mem [CELLS];

    logic              blk_rd_reg;
    node_t             node_rd_reg;
    logic [CELL_W-1:0] path_rd_reg;

    logic              blk_we;
    logic [CELL_W-1:0] blk_wa;
    logic              blk_wd;
    logic [CELL_W-1:0] blk_ra;
    logic              node_we;
    logic [CELL_W-1:0] node_wa;
    node_t             node_wd;
    logic [CELL_W-1:0] node_ra;
    logic              path_we;
    logic [CELL_W-1:0] path_wa;
    logic [CELL_W-1:0] path_wd;
    logic [CELL_W-1:0] path_ra;

    // Sweep counter and its registered copy, which lines up with the memory read data.
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [DIM_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic              pv_reg, pv_next;
    logic [CELL_W-1:0] pidx_reg, pidx_next;
    logic [DIM_W-1:0]  px_reg, px_next, py_reg, py_next;

    logic [CELL_W-1:0] start_reg, start_next, end_reg, end_next;
    logic [DIM_W-1:0]  ex_reg, ex_next, ey_reg, ey_next;

    logic               found_reg, found_next;
    logic [CELL_W-1:0]  best_reg, best_next;
    logic [F_W-1:0]     bf_reg, bf_next;
    node_t              bn_reg, bn_next;
    logic [DIM_W-1:0]   bx_reg, bx_next, by_reg, by_next;

    logic [3:0]         dir_reg, dir_next;
    logic [CELL_W-1:0]  nb_reg, nb_next;
    logic [DIM_W-1:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic [ORDER_W-1:0] ins_reg, ins_next;
    logic               eopen_reg, eopen_next;

    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CELL_W-1:0]  cur_reg, cur_next;
    logic [1:0]         status_reg, status_next;
    logic [CELL_W-1:0]  cell_reg, cell_next;

    // Combinational helpers.
    logic [F_W-1:0]          scan_f;
    logic                    scan_take;
    logic [3:0]              dirs;
    logic signed [DIM_W+1:0] cand_x, cand_y;
    logic                    cand_in;
    logic [CELL_W-1:0]       cand_idx;
    logic [G_W-1:0]          g_new;
    logic [DIM_W-1:0]        hdx, hdy;
    logic [DIM_W:0]          hsum;
    logic [H_W-1:0]          h_new;
    logic [LEN_W-1:0]        rd_addr;

    always_ff @(posedge clk) begin
        if (blk_we)
            blocked_mem[blk_wa] <= blk_wd;
        blk_rd_reg <= blocked_mem[blk_ra];
    end

    always_ff @(posedge clk) begin
        if (node_we)
            node_mem[node_wa] <= node_wd;
        node_rd_reg <= node_mem[node_ra];
    end

    always_ff @(posedge clk) begin
        if (path_we)
            path_mem[path_wa] <= path_wd;
        path_rd_reg <= path_mem[path_ra];
    end

    assign scan_f    = F_W'(node_rd_reg.g) + F_W'(node_rd_reg.h);
    assign scan_take = (node_rd_reg.tag == TAG_OPEN) &&
                       (!found_reg || (scan_f < bf_reg) ||
                        ((scan_f == bf_reg) && (node_rd_reg.order < bn_reg.order)));
    assign dirs      = cfg.diag ? 4'd8 : 4'd4;
    assign cand_x    = $signed({2'b00, bx_reg}) + (DIM_W+2)'(STEP_DX[dir_reg[2:0]]);
    assign cand_y    = $signed({2'b00, by_reg}) + (DIM_W+2)'(STEP_DY[dir_reg[2:0]]);
    assign cand_in   = (cand_x >= 0) && (cand_y >= 0) &&
                       (cand_x < $signed({2'b00, cfg.width})) &&
                       (cand_y < $signed({2'b00, cfg.height}));
    assign cand_idx  = CELL_W'(cand_y[DIM_W-1:0] * cfg.width) +
                       CELL_W'(cand_x[DIM_W-1:0]);
    assign g_new     = bn_reg.g + G_W'(1);
    assign hdx       = (nx_reg > ex_reg) ? nx_reg - ex_reg : ex_reg - nx_reg;
    assign hdy       = (ny_reg > ey_reg) ? ny_reg - ey_reg : ey_reg - ny_reg;
    assign hsum      = {1'b0, hdx} + {1'b0, hdy};
    assign h_new     = cfg.diag ? ((hdx > hdy) ? hdx : hdy) : hsum[H_W-1:0];
    assign rd_addr   = len_reg - LEN_W'(1) - {1'b0, path_step};

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.path_length = len_reg;
    assign res.path_cell   = cell_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        bf_next     = bf_reg;
        bn_next     = bn_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        dir_next    = dir_reg;
        nb_next     = nb_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        ins_next    = ins_reg;
        eopen_next  = eopen_reg;
        len_next    = len_reg;
        cur_next    = cur_reg;
        status_next = status_reg;
        cell_next   = cell_reg;

        blk_we  = 1'b0;
        blk_wa  = cell_index;
        blk_wd  = !cell_passable;
        blk_ra  = cnt_reg[CELL_W-1:0];
        node_we = 1'b0;
        node_wa = pidx_reg;
        node_wd = '0;
        node_ra = cnt_reg[CELL_W-1:0];
        path_we = 1'b0;
        path_wa = len_reg[CELL_W-1:0];
        path_wd = cur_reg;
        path_ra = rd_addr[CELL_W-1:0];

        case (state_reg)
            S_INIT: begin
                // After reset every map cell is written passable, one a cycle.
                blk_we   = 1'b1;
                blk_wa   = cnt_reg[CELL_W-1:0];
                blk_wd   = 1'b0;
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg == LEN_W'(CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE: begin
                if (go) begin
                    status_next = ST_RANGE;
                    cell_next   = '0;
                    state_next  = S_DONE;
                    case (operation)
                        OP_LOAD: begin
                            if ({1'b0, cell_index} < cfg.cells) begin
                                blk_we      = 1'b1;
                                status_next = ST_OK;
                            end
                        end
                        OP_SEARCH: begin
                            if (({1'b0, start_cell} < cfg.cells) &&
                                ({1'b0, end_cell} < cfg.cells)) begin
                                len_next = '0;
                                if (start_cell == end_cell) begin
                                    status_next = ST_OK;
                                end else begin
                                    start_next = start_cell;
                                    end_next   = end_cell;
                                    cnt_next   = '0;
                                    x_next     = '0;
                                    y_next     = '0;
                                    state_next = S_CLEAR;
                                end
                            end
                        end
                        OP_READ: begin
                            if ({1'b0, path_step} < len_reg)
                                state_next = S_PREAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                if (pv_reg) begin
                    node_we     = 1'b1;
                    node_wd.tag = blk_rd_reg ? TAG_DEAD : TAG_NONE;
                    node_wd.parent = NO_PARENT;
                end
                if (cnt_reg < cfg.cells) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[CELL_W-1:0];
                    if (cnt_reg[CELL_W-1:0] == end_reg) begin
                        ex_next = x_reg;
                        ey_next = y_reg;
                    end
                    cnt_next = cnt_reg + LEN_W'(1);
                    if (x_reg == cfg.width - DIM_W'(1)) begin
                        x_next = '0;
                        y_next = y_reg + DIM_W'(1);
                    end else begin
                        x_next = x_reg + DIM_W'(1);
                    end
                end else if (!pv_reg) begin
                    state_next = S_SEED;
                end
            end
            S_SEED: begin
                node_we        = 1'b1;
                node_wa        = start_reg;
                node_wd.tag    = TAG_OPEN;
                node_wd.parent = NO_PARENT;
                ins_next       = ORDER_W'(1);
                eopen_next     = 1'b0;
                cnt_next       = '0;
                x_next         = '0;
                y_next         = '0;
                found_next     = 1'b0;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                if (pv_reg && scan_take) begin
                    found_next = 1'b1;
                    best_next  = pidx_reg;
                    bf_next    = scan_f;
                    bn_next    = node_rd_reg;
                    bx_next    = px_reg;
                    by_next    = py_reg;
                end
                if (cnt_reg < cfg.cells) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[CELL_W-1:0];
                    px_next   = x_reg;
                    py_next   = y_reg;
                    cnt_next  = cnt_reg + LEN_W'(1);
                    if (x_reg == cfg.width - DIM_W'(1)) begin
                        x_next = '0;
                        y_next = y_reg + DIM_W'(1);
                    end else begin
                        x_next = x_reg + DIM_W'(1);
                    end
                end else if (!pv_reg) begin
                    if (found_reg) begin
                        state_next = S_CLOSE;
                    end else begin
                        status_next = ST_NO_PATH;
                        len_next    = '0;
                        state_next  = S_DONE;
                    end
                end
            end
            S_CLOSE: begin
                node_we     = 1'b1;
                node_wa     = best_reg;
                node_wd     = bn_reg;
                node_wd.tag = TAG_CLOSED;
                dir_next    = '0;
                state_next  = S_NB_RD;
            end
            S_NB_RD: begin
                if (dir_reg == dirs) begin
                    if (eopen_reg) begin
                        cur_next   = end_reg;
                        len_next   = '0;
                        state_next = S_WALK;
                    end else begin
                        cnt_next   = '0;
                        x_next     = '0;
                        y_next     = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end else if (cand_in) begin
                    node_ra    = cand_idx;
                    nb_next    = cand_idx;
                    nx_next    = cand_x[DIM_W-1:0];
                    ny_next    = cand_y[DIM_W-1:0];
                    state_next = S_NB_WR;
                end else begin
                    dir_next = dir_reg + 4'd1;
                end
            end
            S_NB_WR: begin
                node_wa = nb_reg;
                node_wd = node_rd_reg;
                case (node_rd_reg.tag)
                    TAG_OPEN: begin
                        if (node_rd_reg.g > g_new) begin
                            node_we        = 1'b1;
                            node_wd.parent = {1'b0, best_reg};
                            node_wd.g      = g_new;
                        end
                    end
                    TAG_CLOSED: begin
                        if ((bn_reg.parent != {1'b0, nb_reg}) &&
                            (node_rd_reg.g > g_new)) begin
                            node_we        = 1'b1;
                            node_wd.parent = {1'b0, best_reg};
                            node_wd.g      = g_new;
                            node_wd.tag    = TAG_OPEN;
                            node_wd.order  = ins_reg;
                            ins_next       = ins_reg + ORDER_W'(1);
                            if (nb_reg == end_reg)
                                eopen_next = 1'b1;
                        end
                    end
                    TAG_NONE: begin
                        node_we        = 1'b1;
                        node_wd.parent = {1'b0, best_reg};
                        node_wd.g      = g_new;
                        node_wd.h      = h_new;
                        node_wd.tag    = TAG_OPEN;
                        node_wd.order  = ins_reg;
                        ins_next       = ins_reg + ORDER_W'(1);
                        if (nb_reg == end_reg)
                            eopen_next = 1'b1;
                    end
                    default: ;
                endcase
                dir_next   = dir_reg + 4'd1;
                state_next = S_NB_RD;
            end
            S_WALK: begin
                // The path is kept from the goal backwards; reads mirror the index.
                node_ra    = cur_reg;
                path_we    = 1'b1;
                len_next   = len_reg + LEN_W'(1);
                state_next = S_WCHK;
            end
            S_WCHK: begin
                if ((node_rd_reg.parent >= cfg.cells) || (len_reg == cfg.cells)) begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end else begin
                    cur_next   = node_rd_reg.parent[CELL_W-1:0];
                    state_next = S_WALK;
                end
            end
            S_PREAD: begin
                cell_next   = path_rd_reg;
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_INIT;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            eopen_reg  <= 1'b0;
            len_reg    <= '0;
            status_reg <= ST_OK;
            cell_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pv_reg     <= pv_next;
            found_reg  <= found_next;
            eopen_reg  <= eopen_next;
            len_reg    <= len_next;
            status_reg <= status_next;
            cell_reg   <= cell_next;
        end
    end

    always_ff @(posedge clk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        pidx_reg  <= pidx_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        best_reg  <= best_next;
        bf_reg    <= bf_next;
        bn_reg    <= bn_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        dir_reg   <= dir_next;
        nb_reg    <= nb_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        ins_reg   <= ins_next;
        cur_reg   <= cur_next;
    end

endmodule

// File: hdl/grid_astar_path_search_unit.sv
// ----------------------------------------------------------------------------
// Grid A* path search unit
// A* search on a grid map held in memory, with path readback one cell a time.
// ----------------------------------------------------------------------------
//  channel   dir   role
//  in_ch     in    load cell / run search / read path step items
//  out_ch    out   one result item for every input item
//  apb       in    grid width, grid height, neighbour mode registers
//
// A load passes from idle through the done state; a path read adds a path read state.
// A search clears the node memory, then each expansion scans it one entry a cycle and
// reads and updates each neighbour in turn, all through the single node memory read port.
// The path walk passes each path cell through a walk state and a check state.
// One item is in work at a time; a finished result waits in the output register.
// After reset the map is cleared to passable with the input held off.
module grid_astar_path_search_unit
    import gasp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gasp_in_if.sink            in_ch,
    gasp_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    grid_cfg_t cfg;
    logic      core_idle;
    logic      core_valid;
    logic      core_ready;
    result_t   core_res;
    logic      go;

    logic      out_valid_reg;
    result_t   out_res_reg;

    gasp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ch.ready = core_idle;
    assign go          = in_ch.valid && core_idle;

    gasp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .go            (go),
        .operation     (in_ch.operation),
        .cell_index    (in_ch.cell_index),
        .cell_passable (in_ch.cell_passable),
        .start_cell    (in_ch.start_cell),
        .end_cell      (in_ch.end_cell),
        .path_step     (in_ch.path_step),
        .idle          (core_idle),
        .res_valid     (core_valid),
        .res_ready     (core_ready),
        .res           (core_res)
    );

    assign core_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_ready)
            out_valid_reg <= core_valid;
    end

    always_ff @(posedge clk) begin
        if (core_ready && core_valid)
            out_res_reg <= core_res;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_res_reg.status;
    assign out_ch.path_length = out_res_reg.path_length;
    assign out_ch.path_cell   = out_res_reg.path_cell;

endmodule

// File: hdl/gasp_checker.sv
// ----------------------------------------------------------------------------
// Grid A* path search port checker
// Port-level properties over time, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_unit_defines.svh"

module gasp_checker
    import gasp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        status,
    input logic [LEN_W-1:0]  path_length,
    input logic [CELL_W-1:0] path_cell
);

    // One item is worked on at a time, so acceptance closes the input.
    `GASP_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "item accepted while busy")

    // Only a successful path read reports a cell.
    `GASP_ASSERT_NOW(a_cell_zero, out_valid && (status != ST_OK), path_cell == '0, "stray path cell")

    `GASP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    `GASP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                      $stable(status) && $stable(path_length) && $stable(path_cell),
                      "result changed while stalled")

endmodule

bind grid_astar_path_search_unit gasp_checker u_gasp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .path_length (out_ch.path_length),
    .path_cell   (out_ch.path_cell)
);
